// ===== hw/rtl/single_hash_bloom_filter_macros.svh =====
// Assertion macros shared by the single-hash Bloom filter RTL.
`ifndef SINGLE_HASH_BLOOM_FILTER_MACROS_SVH
`define SINGLE_HASH_BLOOM_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbf assertion failed");

`endif

// ===== hw/rtl/sbf_pkg.sv =====
// Shared types and constants of the single-hash Bloom filter.
package sbf_pkg;

    localparam int DEFAULT_MAX_WORDS = 64;
    localparam int CFG_W             = 7;
    localparam int HASH_W            = 64;
    localparam int WORD_W            = 64;
    localparam int IDX_W             = 6;
    localparam int BITPOS_W          = 12;
    localparam int LOW_BITS          = 6;
    localparam int DVD_W             = 2 * HASH_W - LOW_BITS;
    localparam int RADIX_STEPS       = DVD_W / 2;
    localparam int STEP_CNT_W        = $clog2(RADIX_STEPS);

    localparam logic [CFG_W-1:0] RESET_FILTER_WORDS = CFG_W'(8);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_WRITE  = 2'd3;

    typedef struct packed {
        logic [1:0]          op;
        logic [CFG_W-1:0]    word;
        logic [LOW_BITS-1:0] bitsel;
        logic [BITPOS_W-1:0] pos;
        logic                in_range;
        logic [WORD_W-1:0]   wdata;
    } t_job;

endpackage

// ===== hw/rtl/sbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/sbf_queue.sv =====
// Two-entry job queue between the front and back parts.
module sbf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbf_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sbf_pkg::t_job o_job
);
    import sbf_pkg::*;

    t_job       r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_slot[r_rd_ptr];
endmodule

// ===== hw/rtl/sbf_front.sv =====
// Front part: takes commands, reduces the key hash with a radix-4 remainder loop.
`include "single_hash_bloom_filter_macros.svh"
module sbf_front #(
    parameter int MAX_WORDS = sbf_pkg::DEFAULT_MAX_WORDS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [1:0]                   i_op,
    input  logic [sbf_pkg::HASH_W-1:0]   i_key_hash_high,
    input  logic [sbf_pkg::HASH_W-1:0]   i_key_hash_low,
    input  logic [sbf_pkg::IDX_W-1:0]    i_word_index,
    input  logic [sbf_pkg::WORD_W-1:0]   i_word_value,
    input  logic [sbf_pkg::CFG_W-1:0]    i_filter_words,
    input  logic                         i_queue_full,
    output logic                         o_idle,
    output logic                         o_push,
    output sbf_pkg::t_job                o_job
);
    import sbf_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate               r_state, n_state;
    logic [DVD_W-1:0]      r_dvd;
    logic [CFG_W-1:0]      r_rem, n_rem;
    logic [CFG_W-1:0]      r_words;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [1:0]            r_op;
    logic [LOW_BITS-1:0]   r_low;
    logic [IDX_W-1:0]      r_widx;
    logic [WORD_W-1:0]     r_wval;
    logic [CFG_W-1:0]      words;
    logic [CFG_W:0]        t1, t2;
    logic [CFG_W-1:0]      r1;
    logic                  key_op;

    always_comb begin
        words = i_filter_words;
        if (i_filter_words == '0) begin
            words = CFG_W'(1);
        end else if (32'(i_filter_words) > MAX_WORDS) begin
            words = CFG_W'(MAX_WORDS);
        end
    end

    // two restoring steps per cycle
    always_comb begin
        t1 = {r_rem, r_dvd[DVD_W-1]};
        if (t1 >= {1'b0, r_words}) begin
            t1 = t1 - {1'b0, r_words};
        end
        r1 = t1[CFG_W-1:0];
        t2 = {r1, r_dvd[DVD_W-2]};
        if (t2 >= {1'b0, r_words}) begin
            t2 = t2 - {1'b0, r_words};
        end
        n_rem = t2[CFG_W-1:0];
    end

    assign key_op = (r_op == OP_INSERT) || (r_op == OP_QUERY);
    assign o_idle = (r_state == F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_queue_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_accept) begin
                    n_state = ((i_op == OP_INSERT) || (i_op == OP_QUERY)) ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                if (r_cnt == '0) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_queue_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_accept) begin
            r_dvd   <= {i_key_hash_high, i_key_hash_low[HASH_W-1:LOW_BITS]};
            r_low   <= i_key_hash_low[LOW_BITS-1:0];
            r_rem   <= '0;
            r_cnt   <= STEP_CNT_W'(RADIX_STEPS - 1);
            r_words <= words;
            r_op    <= i_op;
            r_widx  <= i_word_index;
            r_wval  <= i_word_value;
        end else if (r_state == F_DIV) begin
            r_dvd <= {r_dvd[DVD_W-3:0], 2'b00};
            r_rem <= n_rem;
            r_cnt <= r_cnt - STEP_CNT_W'(1);
        end
    end

    always_comb begin
        o_job.op       = r_op;
        o_job.wdata    = r_wval;
        o_job.bitsel   = r_low;
        if (key_op) begin
            o_job.word     = r_rem;
            o_job.pos      = BITPOS_W'({r_rem, r_low});
            o_job.in_range = 1'b1;
        end else begin
            o_job.word     = {1'b0, r_widx};
            o_job.pos      = '0;
            o_job.in_range = ({1'b0, r_widx} < r_words);
        end
    end

    `SBF_ASSERT_IMPL(a_rem_below_divisor, i_clk, i_rst_n, r_state == F_DIV, r_rem < r_words)
    `SBF_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, o_push, !i_queue_full)
endmodule

// ===== hw/rtl/sbf_back.sv =====
// Back part: clears the store after reset, runs read-modify-write jobs, drives results.
`include "single_hash_bloom_filter_macros.svh"
module sbf_back #(
    parameter int MAX_WORDS = sbf_pkg::DEFAULT_MAX_WORDS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  sbf_pkg::t_job                i_job,
    output logic                         o_pop,
    output logic                         o_clearing,
    output logic                         o_done,
    output logic                         o_hit,
    output logic [sbf_pkg::BITPOS_W-1:0] o_bit_position,
    output logic [sbf_pkg::WORD_W-1:0]   o_word_out
);
    import sbf_pkg::*;

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_EXEC  = 3'b100
    } t_bstate;

    t_bstate             r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    t_job                r_job;
    logic                r_done;
    logic                r_hit;
    logic [BITPOS_W-1:0] r_pos;
    logic [WORD_W-1:0]   r_word;
    logic [WORD_W-1:0]   rdata;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [WORD_W-1:0]   wdata;

    assign o_pop      = (r_state == B_IDLE) && i_job_valid;
    assign o_clearing = (r_state == B_CLEAR);

    sbf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (o_pop),
        .i_raddr (AW'(i_job.word)),
        .o_rdata (rdata)
    );

    always_comb begin
        we    = 1'b0;
        waddr = AW'(r_job.word);
        wdata = rdata | (WORD_W'(1) << r_job.bitsel);
        case (r_state)
            B_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_addr;
                wdata = '0;
            end
            B_EXEC: begin
                if (r_job.op == OP_INSERT) begin
                    we = 1'b1;
                end else if (r_job.op == OP_WRITE && r_job.in_range) begin
                    we    = 1'b1;
                    wdata = r_job.wdata;
                end
            end
            default: we = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: begin
                if (r_clr_addr == AW'(MAX_WORDS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_job_valid) begin
                    n_state = B_EXEC;
                end
            end
            B_EXEC:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == B_EXEC);
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_EXEC) begin
            r_hit  <= (r_job.op == OP_QUERY) && rdata[r_job.bitsel];
            r_pos  <= r_job.pos;
            r_word <= (r_job.op == OP_READ && r_job.in_range) ? rdata : '0;
        end
    end

    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_bit_position = r_pos;
    assign o_word_out     = r_word;

    `SBF_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, r_state == B_EXEC, r_done)
    `SBF_ASSERT_IMPL(a_no_pop_in_clear, i_clk, i_rst_n, r_state == B_CLEAR, !o_pop)
    `SBF_ASSERT_IMPL(a_result_after_exec, i_clk, i_rst_n, r_done, $past(r_state) == B_EXEC)
endmodule

// ===== hw/rtl/single_hash_bloom_filter.sv =====
// Single-hash Bloom filter over a store of 64-bit words.
//
// Command channel: a transaction is taken on a rising edge with start high and
// busy low. Ops: insert key, query key, read word, write word. Keys arrive as a
// 128-bit hash; its bit index is hash mod (64 * active words).
// Result channel: o_done is high for one cycle with o_hit, o_bit_position and
// o_word_out; the receiver has no way to stall it and must take it then.
// Config channel: i_cfg_valid/o_cfg_ready writes the active word count
// (0 reads as 1, values above MAX_WORDS saturate); write it only while idle.
// Flow: a key op passes through 61 radix-4 remainder steps over the 122-bit upper
// hash, the hand-off of the job to the queue (held while the queue is full), a pop
// with the store read and a read-modify-write before o_done rises; word ops skip
// the remainder steps. A new command can be taken while the back part still works
// on the last one. One command is in the front at a time, so busy stays high until
// the front has handed the job to the back part's queue.
// Reset: the word count returns to 8 and the store is cleared by a pass over all
// MAX_WORDS words, during which busy stays high.
module single_hash_bloom_filter #(
    parameter int MAX_WORDS = sbf_pkg::DEFAULT_MAX_WORDS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_op,
    input  logic [sbf_pkg::HASH_W-1:0]   i_key_hash_high,
    input  logic [sbf_pkg::HASH_W-1:0]   i_key_hash_low,
    input  logic [sbf_pkg::IDX_W-1:0]    i_word_index,
    input  logic [sbf_pkg::WORD_W-1:0]   i_word_value,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sbf_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_done,
    output logic                         o_hit,
    output logic [sbf_pkg::BITPOS_W-1:0] o_bit_position,
    output logic [sbf_pkg::WORD_W-1:0]   o_word_out
);
    import sbf_pkg::*;

    logic [CFG_W-1:0] r_filter_words;
    logic             front_idle;
    logic             clearing;
    logic             push, pop, q_full, q_valid;
    t_job             push_job, pop_job;

    assign o_cfg_ready = 1'b1;
    assign busy        = !front_idle || clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_words <= RESET_FILTER_WORDS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_filter_words <= i_cfg_data;
        end
    end

    sbf_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (start && !busy),
        .i_op            (i_op),
        .i_key_hash_high (i_key_hash_high),
        .i_key_hash_low  (i_key_hash_low),
        .i_word_index    (i_word_index),
        .i_word_value    (i_word_value),
        .i_filter_words  (r_filter_words),
        .i_queue_full    (q_full),
        .o_idle          (front_idle),
        .o_push          (push),
        .o_job           (push_job)
    );

    sbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    sbf_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (pop_job),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_bit_position (o_bit_position),
        .o_word_out     (o_word_out)
    );
endmodule

// ===== verif/tb_single_hash_bloom_filter.sv =====
// Testbench for single_hash_bloom_filter: directed and random commands checked by a scoreboard.
module tb_single_hash_bloom_filter;
    import sbf_pkg::*;

    localparam int NUM_WORDS       = DEFAULT_MAX_WORDS;
    localparam int KEY_W           = 2 * HASH_W;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int POOL_DEPTH      = 32;
    localparam int DRAIN_CYCLES    = 100;
    localparam int SETTLE_LIMIT    = 20000;
    localparam int TIMEOUT_CYCLES  = 1_000_000;

    typedef struct packed {
        logic [1:0]          op;
        logic                hit;
        logic [BITPOS_W-1:0] pos;
        logic [WORD_W-1:0]   word;
    } t_bloom_result;

    class bloom_scoreboard;
        logic [WORD_W-1:0] store [NUM_WORDS];
        logic [CFG_W-1:0]  word_count;
        t_bloom_result     expected_q[$];
        int errors, checked;
        int n_insert, n_query, n_hit, n_read, n_write, n_outside, n_cfg;

        function new();
            foreach (store[i]) store[i] = '0;
            word_count = RESET_FILTER_WORDS;
        endfunction

        function int active_words();
            if (word_count == '0) return 1;
            if (int'(word_count) > NUM_WORDS) return NUM_WORDS;
            return int'(word_count);
        endfunction

        function void set_word_count(logic [CFG_W-1:0] value);
            word_count = value;
            n_cfg++;
        endfunction

        // Predict the result of an accepted transaction and update the store copy.
        function void note_command(logic [1:0] op, logic [HASH_W-1:0] hash_high,
                                   logic [HASH_W-1:0] hash_low, logic [IDX_W-1:0] widx,
                                   logic [WORD_W-1:0] wval);
            t_bloom_result     res;
            logic [KEY_W-1:0]  divisor;
            logic [KEY_W-1:0]  bit_index;
            int unsigned       sel;
            res = '0;
            res.op = op;
            if (op == OP_INSERT || op == OP_QUERY) begin
                divisor = active_words() * WORD_W;
                bit_index = {hash_high, hash_low} % divisor;
                res.pos = bit_index[BITPOS_W-1:0];
                sel = bit_index[BITPOS_W-1:LOW_BITS] % NUM_WORDS;
                if (op == OP_INSERT) begin
                    store[sel][bit_index[LOW_BITS-1:0]] = 1'b1;
                    n_insert++;
                end else begin
                    res.hit = store[sel][bit_index[LOW_BITS-1:0]];
                    n_query++;
                    if (res.hit) n_hit++;
                end
            end else if (int'(widx) < active_words()) begin
                if (op == OP_READ) begin
                    res.word = store[widx];
                    n_read++;
                end else begin
                    store[widx] = wval;
                    n_write++;
                end
            end else begin
                n_outside++;
            end
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic hit, logic [BITPOS_W-1:0] pos, logic [WORD_W-1:0] word);
            t_bloom_result exp_res;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result: hit %0b pos %0d word %h", hit, pos, word));
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (hit !== exp_res.hit)
                report($sformatf("result %0d op %0d hit: got %0b, expected %0b",
                                 checked, exp_res.op, hit, exp_res.hit));
            if (pos !== exp_res.pos)
                report($sformatf("result %0d op %0d bit_position: got %0d, expected %0d",
                                 checked, exp_res.op, pos, exp_res.pos));
            if (word !== exp_res.word)
                report($sformatf("result %0d op %0d word_out: got %h, expected %h",
                                 checked, exp_res.op, word, exp_res.word));
        endtask
    endclass

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                start           = 1'b0;
    logic                busy;
    logic [1:0]          i_op            = OP_INSERT;
    logic [HASH_W-1:0]   i_key_hash_high = '0;
    logic [HASH_W-1:0]   i_key_hash_low  = '0;
    logic [IDX_W-1:0]    i_word_index    = '0;
    logic [WORD_W-1:0]   i_word_value    = '0;
    logic                i_cfg_valid     = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data      = '0;
    logic                o_done;
    logic                o_hit;
    logic [BITPOS_W-1:0] o_bit_position;
    logic [WORD_W-1:0]   o_word_out;

    bloom_scoreboard     sb;
    logic [KEY_W-1:0]    key_pool[$];
    logic [CFG_W-1:0]    cfg_plan [NUM_PHASES] = '{7'd64, 7'd1, 7'd0, 7'd127,
                                                   7'd65, 7'd8, 7'd33, 7'd5};

    single_hash_bloom_filter i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_command(i_op, i_key_hash_high, i_key_hash_low, i_word_index,
                                i_word_value);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_word_count(i_cfg_data);
            if (o_done)
                sb.check_result(o_hit, o_bit_position, o_word_out);
        end
    end

    function automatic logic [WORD_W-1:0] rand_wide();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WORD_W'($urandom_range(0, 4095));
            3: return {32'hFFFF_FFFF, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic send_item(logic [1:0] op, logic [HASH_W-1:0] hh, logic [HASH_W-1:0] hl,
                             logic [IDX_W-1:0] widx, logic [WORD_W-1:0] wval);
        start           <= 1'b1;
        i_op            <= op;
        i_key_hash_high <= hh;
        i_key_hash_low  <= hl;
        i_word_index    <= widx;
        i_word_value    <= wval;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        int n;
        start <= 1'b0;
        for (n = 0; n < SETTLE_LIMIT && sb.expected_q.size() != 0; n++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_word_count(logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [1:0]        op;
        logic [HASH_W-1:0] hh;
        logic [HASH_W-1:0] hl;
        logic [IDX_W-1:0]  widx;
        logic [WORD_W-1:0] wval;
        int unsigned       r;
        hh   = rand_wide();
        hl   = rand_wide();
        widx = IDX_W'($urandom);
        wval = rand_wide();
        r    = $urandom_range(0, 99);
        if (r < 35) begin
            op = OP_INSERT;
            key_pool.push_back({hh, hl});
            if (key_pool.size() > POOL_DEPTH) key_pool.delete(0);
        end else if (r < 70) begin
            op = OP_QUERY;
            if (key_pool.size() != 0 && $urandom_range(0, 2) != 0)
                {hh, hl} = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else begin
            op = (r < 85) ? OP_READ : OP_WRITE;
            if ($urandom_range(0, 9) < 7)
                widx = IDX_W'($urandom_range(0, sb.active_words() - 1));
        end
        send_item(op, hh, hl, widx, wval);
    endtask

    initial begin
        int burst_left;
        int phase;
        int k;
        sb = new();
        burst_left = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset word count of 8, 512 bits
        send_item(OP_QUERY,  '0, '0, '0, '0);
        send_item(OP_INSERT, '0, '0, '1, '1);
        send_item(OP_QUERY,  '0, '0, '1, '1);
        send_item(OP_INSERT, '1, '1, '0, '0);
        send_item(OP_QUERY,  '1, '1, '0, '0);
        send_item(OP_INSERT, '1, '0, '0, '0);
        send_item(OP_INSERT, '0, '1, '0, '0);
        send_item(OP_QUERY,  '0, 64'd511, '0, '0);
        send_item(OP_READ,   '1, '1, 6'd0, '1);
        send_item(OP_READ,   '0, '0, 6'd7, '0);
        send_item(OP_READ,   '0, '0, 6'd8, '0);
        send_item(OP_READ,   '0, '0, 6'd63, '0);
        send_item(OP_WRITE,  '1, '1, 6'd7, '1);
        send_item(OP_READ,   '0, '0, 6'd7, '0);
        send_item(OP_WRITE,  '0, '0, 6'd8, '1);
        send_item(OP_READ,   '0, '0, 6'd8, '0);
        send_item(OP_WRITE,  '0, '0, 6'd0, '0);
        send_item(OP_QUERY,  '0, '0, '0, '0);
        send_item(OP_WRITE,  '0, '0, 6'd3, 64'hA5A5_5A5A_F00F_0FF0);
        send_item(OP_READ,   '0, '0, 6'd3, '0);
        send_item(OP_QUERY,  '0, 64'd200, '0, '0);

        cfg_plan[NUM_PHASES-1] = CFG_W'($urandom_range(2, 63));
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            write_word_count(cfg_plan[phase]);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    pause(($urandom_range(0, 3) == 0) ? $urandom_range(20, 90)
                                                      : $urandom_range(0, 6));
                end
                random_item();
                burst_left--;
            end
        end
        settle();

        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));
        $display("Ran %0d inserts, %0d queries (%0d hits), %0d reads, %0d writes, %0d out-of-range",
                 sb.n_insert, sb.n_query, sb.n_hit, sb.n_read, sb.n_write, sb.n_outside);
        $display("Word count set %0d times (0, 1, 64, 127 included); %0d results, %0d mismatches",
                 sb.n_cfg, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("** single_hash_bloom_filter: PASSED **");
        else
            $display("** single_hash_bloom_filter: FAILED **");
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("** single_hash_bloom_filter: FAILED **");
        $finish;
    end

endmodule

// ===== single_hash_bloom_filter.f =====
+incdir+hw/rtl
hw/rtl/sbf_pkg.sv
hw/rtl/sbf_ram.sv
hw/rtl/sbf_queue.sv
hw/rtl/sbf_front.sv
hw/rtl/sbf_back.sv
hw/rtl/single_hash_bloom_filter.sv
verif/tb_single_hash_bloom_filter.sv
